[rtl/ilp_pkg.sv]
// Shared widths, types and defaults for the integer literal parser.
package ilp_pkg;

  localparam int unsigned CharWidth        = 8;
  localparam int unsigned ValueWidth       = 32;
  localparam int unsigned DefaultValueBits = 32;

  typedef logic        [CharWidth-1:0]  char_t;
  typedef logic signed [ValueWidth-1:0] value_t;

endpackage

[rtl/ilp_if.sv]
// Valid/ready channel interfaces for parser input and result items.
interface ilp_in_if;
  import ilp_pkg::*;

  logic  valid;
  logic  ready;
  char_t char_code;
  logic  string_start;

  modport source (output valid, output char_code, output string_start, input ready);
  modport sink   (input valid, input char_code, input string_start, output ready);
endinterface

interface ilp_out_if;
  import ilp_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[rtl/integer_literal_parser_unit.sv]
// Streaming signed integer literal parser: one character per item, at most one value per string.
// The item that ends the literal passes the input register, then the result register.
// Throughput: one item per cycle while the result channel is not stalled; the accumulator is
// updated by shift-and-add in the parse-state loop.
// Reset: asynchronous, active low; clears the parse phase, sign, accumulator and valid flags.
// A string_start item clears the parse state before its character is used.
module integer_literal_parser_unit #(
  parameter int unsigned VALUE_BITS = ilp_pkg::DefaultValueBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ilp_in_if.sink      in_i,
  ilp_out_if.source   out_o
);
  import ilp_pkg::*;

  localparam logic [2:0] PH_LEAD     = 3'd0;
  localparam logic [2:0] PH_POSTSIGN = 3'd1;
  localparam logic [2:0] PH_ZERO     = 3'd2;
  localparam logic [2:0] PH_HEX      = 3'd3;
  localparam logic [2:0] PH_OCT      = 3'd4;
  localparam logic [2:0] PH_DEC      = 3'd5;
  localparam logic [2:0] PH_DONE     = 3'd6;

  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_0     = 8'h30;
  localparam char_t CH_1     = 8'h31;
  localparam char_t CH_7     = 8'h37;
  localparam char_t CH_9     = 8'h39;
  localparam char_t CH_UA    = 8'h41;
  localparam char_t CH_UF    = 8'h46;
  localparam char_t CH_UX    = 8'h58;
  localparam char_t CH_LA    = 8'h61;
  localparam char_t CH_LF    = 8'h66;
  localparam char_t CH_LX    = 8'h78;

  typedef logic [VALUE_BITS-1:0] acc_t;

  // input register
  logic  s1_valid_q, s1_valid_d;
  char_t s1_char_q;
  logic  s1_start_q;

  // parse state
  logic [2:0] ph_q, ph_d;
  acc_t       acc_q, acc_d;
  logic       neg_q, neg_d;

  // result register
  logic   out_valid_q, out_valid_d;
  value_t out_value_q, out_value_d;

  logic adv, proc, emit;
  logic [2:0] ph_cur;
  acc_t       acc_cur, acc_shift, fin_val;
  logic       neg_cur;
  char_t      c;
  logic       is_blank, is_sign, is_dec, is_oct, is_lhex, is_uhex, is_x;
  logic [3:0] dec_digit, hex_digit;

  assign adv        = !out_valid_q || out_o.ready;
  assign proc       = s1_valid_q && adv;
  assign in_i.ready = !s1_valid_q || adv;

  assign c        = s1_char_q;
  assign ph_cur   = s1_start_q ? PH_LEAD : ph_q;
  assign acc_cur  = s1_start_q ? '0 : acc_q;
  assign neg_cur  = s1_start_q ? 1'b0 : neg_q;

  assign is_blank  = (c == CH_SPACE) || (c == CH_TAB);
  assign is_sign   = (c == CH_PLUS) || (c == CH_MINUS);
  assign is_dec    = (c >= CH_0) && (c <= CH_9);
  assign is_oct    = (c >= CH_0) && (c <= CH_7);
  assign is_lhex   = (c >= CH_LA) && (c <= CH_LF);
  assign is_uhex   = (c >= CH_UA) && (c <= CH_UF);
  assign is_x      = (c == CH_LX) || (c == CH_UX);
  assign dec_digit = 4'(c - CH_0);

  always_comb begin
    if (is_lhex) begin
      hex_digit = 4'(c - CH_LA + 8'd10);
    end else if (is_uhex) begin
      hex_digit = 4'(c - CH_UA + 8'd10);
    end else begin
      hex_digit = dec_digit;
    end
  end

  assign fin_val     = neg_cur ? acc_t'(-acc_cur) : acc_cur;
  assign out_value_d = value_t'(ValueWidth'(fin_val));

  always_comb begin
    ph_d      = ph_cur;
    acc_d     = acc_cur;
    neg_d     = neg_cur;
    emit      = 1'b0;
    acc_shift = acc_cur;
    unique case (ph_cur)
      PH_LEAD, PH_POSTSIGN: begin
        if (is_blank) begin
          ph_d = ph_cur;
        end else if ((ph_cur == PH_LEAD) && is_sign) begin
          neg_d = (c == CH_MINUS);
          ph_d  = PH_POSTSIGN;
        end else if (c == CH_0) begin
          ph_d = PH_ZERO;
        end else if ((c >= CH_1) && (c <= CH_9)) begin
          acc_d = acc_t'(dec_digit);
          ph_d  = PH_DEC;
        end else begin
          emit = 1'b1;
        end
      end
      PH_ZERO: begin
        if (is_x) begin
          ph_d = PH_HEX;
        end else if (is_oct) begin
          acc_d = acc_t'(dec_digit);
          ph_d  = PH_OCT;
        end else begin
          emit = 1'b1;
        end
      end
      PH_HEX: begin
        acc_shift = acc_cur << 4;
        if (is_dec || is_lhex || is_uhex) begin
          acc_d = acc_shift + acc_t'(hex_digit);
        end else begin
          emit = 1'b1;
        end
      end
      PH_OCT: begin
        acc_shift = acc_cur << 3;
        if (is_oct) begin
          acc_d = acc_shift + acc_t'(dec_digit);
        end else begin
          emit = 1'b1;
        end
      end
      PH_DEC: begin
        acc_shift = (acc_cur << 3) + (acc_cur << 1);
        if (is_dec) begin
          acc_d = acc_shift + acc_t'(dec_digit);
        end else begin
          emit = 1'b1;
        end
      end
      default: begin
        ph_d = PH_DONE;
      end
    endcase
    if (emit) begin
      ph_d = PH_DONE;
    end
  end

  // NUL is never a digit, so it lands in the emit arm above in every phase but done
  assign s1_valid_d  = in_i.ready ? in_i.valid : s1_valid_q;
  assign out_valid_d = adv ? (proc && emit) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ph_q        <= PH_LEAD;
      acc_q       <= '0;
      neg_q       <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (proc) begin
        ph_q  <= ph_d;
        acc_q <= acc_d;
        neg_q <= neg_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_char_q  <= in_i.char_code;
      s1_start_q <= in_i.string_start;
    end
    if (proc && emit) begin
      out_value_q <= out_value_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.value = out_value_q;

  // a result always leaves the parser in the done phase
  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && emit) |=> (ph_q == PH_DONE))
    else $error("result emitted without entering done phase");

  // once done, characters without a start mark give no result
  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && (ph_q == PH_DONE) && !s1_start_q) |=> !out_valid_q)
    else $error("result produced after literal finished");

  // a start mark with a terminator must produce a result of zero
  a_start_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && s1_start_q && (s1_char_q == CH_NUL)) |=> (out_valid_q && (out_value_q == '0)))
    else $error("empty string did not give zero");

endmodule

[tb/tb.sv]
// Self-checking testbench for the streaming integer literal parser.
module tb;
  import ilp_pkg::*;

  localparam int unsigned LimitCycles = 400000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned PhaseItems  = 333;

  localparam char_t ChNul   = 8'h00;
  localparam char_t ChTab   = 8'h09;
  localparam char_t ChSpace = 8'h20;
  localparam char_t ChPlus  = "+";
  localparam char_t ChMinus = "-";
  localparam char_t ChZero  = "0";
  localparam char_t ChLowX  = "x";
  localparam char_t ChUpX   = "X";

  typedef enum logic [2:0] {
    ScanLead, ScanPostSign, SeenZero, HexDigits, OctDigits, DecDigits, Finished
  } parse_phase_e;

  typedef struct {
    char_t  ch;
    logic   start;
    bit     typed;
    value_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  ilp_in_if  in_ch ();
  ilp_out_if out_ch ();

  integer_literal_parser_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  parse_phase_e                   pred_phase;
  logic [DefaultValueBits-1:0]    pred_acc;
  bit                             pred_neg;

  value_t    expected_values[$];
  char_t     lit_chars[$];
  int        lit_len;
  int        src_idle;
  int        snk_idle;
  int        errors;
  int        cycles;
  int        items_sent;
  int        values_checked;
  bit        row_typed;
  value_t    row_want;
  value_t    pred_val;
  value_t    head_val;

  stim_row_t directed[] = '{
    '{"5",    1'b0, 1'b0, 32'sd0},
    '{8'hff,  1'b0, 1'b1, 32'sd5},
    '{ChLowX, 1'b0, 1'b0, 32'sd0},
    '{"q",    1'b1, 1'b1, 32'sd0},
    '{ChPlus, 1'b1, 1'b0, 32'sd0},
    '{ChMinus,1'b0, 1'b1, 32'sd0},
    '{ChZero, 1'b1, 1'b0, 32'sd0},
    '{ChNul,  1'b0, 1'b1, 32'sd0},
    '{ChZero, 1'b1, 1'b0, 32'sd0},
    '{"9",    1'b0, 1'b1, 32'sd0},
    '{ChZero, 1'b1, 1'b0, 32'sd0},
    '{ChUpX,  1'b0, 1'b0, 32'sd0},
    '{"g",    1'b0, 1'b1, 32'sd0},
    '{ChSpace,1'b1, 1'b0, 32'sd0},
    '{ChTab,  1'b0, 1'b0, 32'sd0},
    '{ChMinus,1'b0, 1'b0, 32'sd0},
    '{ChSpace,1'b0, 1'b0, 32'sd0},
    '{ChZero, 1'b0, 1'b0, 32'sd0},
    '{ChLowX, 1'b0, 1'b0, 32'sd0},
    '{"F",    1'b0, 1'b0, 32'sd0},
    '{"f",    1'b0, 1'b0, 32'sd0},
    '{ChNul,  1'b0, 1'b1, -32'sd255},
    '{ChZero, 1'b1, 1'b0, 32'sd0},
    '{"1",    1'b0, 1'b0, 32'sd0},
    '{"7",    1'b0, 1'b0, 32'sd0},
    '{"8",    1'b0, 1'b0, 32'sd0}
  };

  function automatic int digit_value(char_t c, int unsigned base);
    int d;
    d = -1;
    if (c >= "0" && c <= "9") d = int'(c - "0");
    else if (base == 16 && c >= "a" && c <= "f") d = int'(c - "a") + 10;
    else if (base == 16 && c >= "A" && c <= "F") d = int'(c - "A") + 10;
    if (d >= int'(base)) d = -1;
    return d;
  endfunction

  function automatic value_t literal_value();
    logic [DefaultValueBits-1:0] v;
    v = pred_neg ? -pred_acc : pred_acc;
    pred_phase = Finished;
    return value_t'(v[ValueWidth-1:0]);
  endfunction

  // Advances the parse state by one character; returns 1 when a value is produced.
  function automatic bit parse_char(input char_t c, input logic s, output value_t v);
    int unsigned base;
    int d;
    v = '0;
    if (s) begin
      pred_phase = ScanLead;
      pred_acc   = '0;
      pred_neg   = 1'b0;
    end
    case (pred_phase)
      ScanLead, ScanPostSign: begin
        if (c == ChSpace || c == ChTab) return 1'b0;
        if (pred_phase == ScanLead && (c == ChMinus || c == ChPlus)) begin
          pred_neg   = (c == ChMinus);
          pred_phase = ScanPostSign;
          return 1'b0;
        end
        if (c == ChZero) begin
          pred_phase = SeenZero;
          return 1'b0;
        end
        if (c >= "1" && c <= "9") begin
          pred_acc   = DefaultValueBits'(c - "0");
          pred_phase = DecDigits;
          return 1'b0;
        end
        v = literal_value();
        return 1'b1;
      end
      SeenZero: begin
        if (c == ChLowX || c == ChUpX) begin
          pred_phase = HexDigits;
          return 1'b0;
        end
        if (c >= "0" && c <= "7") begin
          pred_acc   = DefaultValueBits'(c - "0");
          pred_phase = OctDigits;
          return 1'b0;
        end
        v = literal_value();
        return 1'b1;
      end
      HexDigits, OctDigits, DecDigits: begin
        base = (pred_phase == HexDigits) ? 16 : ((pred_phase == OctDigits) ? 8 : 10);
        d = digit_value(c, base);
        if (d < 0) begin
          v = literal_value();
          return 1'b1;
        end
        pred_acc = pred_acc * base + DefaultValueBits'(d);
        return 1'b0;
      end
      default: begin
        pred_phase = Finished;
        return 1'b0;
      end
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle);
  end

  // Results are checked before the new input is predicted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_values.size() == 0) begin
          $error("value: expected none, got %0d", out_ch.value);
          errors++;
        end else begin
          head_val = expected_values.pop_front();
          values_checked++;
          if (out_ch.value !== head_val) begin
            $error("value: expected %0d, got %0d", head_val, out_ch.value);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (parse_char(in_ch.char_code, in_ch.string_start, pred_val) && !row_typed)
          expected_values.push_back(pred_val);
        if (row_typed) expected_values.push_back(row_want);
      end
    end
  end

  task automatic send_item(input char_t c, input logic s, input bit typed, input value_t want);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.char_code    <= c;
    in_ch.string_start <= s;
    row_typed          <= typed;
    row_want           <= want;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (expected_values.size() != 0) @(negedge clk_i);
  endtask

  task automatic build_string();
    string       txt;
    string       hex_set;
    bit   [31:0] v;
    int          kind;
    int          base_sel;
    int          ndig;
    int          k;
    char_t       ch;
    hex_set = "0123456789abcdefABCDEF";
    lit_chars.delete();
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 6)) lit_chars.push_back(char_t'($urandom_range(255)));
      lit_len = lit_chars.size();
      return;
    end
    repeat ($urandom_range(2)) lit_chars.push_back($urandom_range(1) ? ChSpace : ChTab);
    case ($urandom_range(2))
      1: lit_chars.push_back(ChPlus);
      2: lit_chars.push_back(ChMinus);
      default: ;
    endcase
    // possibly broken: an extra sign, or one more blank after leading blanks or the sign
    if (kind < 18) lit_chars.push_back($urandom_range(1) ? ChPlus : ChMinus);
    else if (lit_chars.size() != 0 && $urandom_range(1))
      lit_chars.push_back($urandom_range(1) ? ChSpace : ChTab);
    base_sel = $urandom_range(2);
    if ($urandom_range(1)) begin
      case ($urandom_range(7))
        0: v = 32'h7fff_ffff;
        1: v = 32'h8000_0000;
        2: v = 32'hffff_ffff;
        3: v = 32'h0;
        default: v = $urandom;
      endcase
      case (base_sel)
        0: txt = $sformatf("%0d", v);
        1: txt = $sformatf("0%0o", v);
        default: begin
          if ($urandom_range(1)) txt = "0x";
          else txt = "0X";
          txt = {txt, $sformatf("%0h", v)};
        end
      endcase
    end else begin
      ndig = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 6);
      case (base_sel)
        0: begin
          txt = "";
          if (ndig != 0) txt = $sformatf("%0d", $urandom_range(1, 9));
          repeat (ndig > 0 ? ndig - 1 : 0) txt = {txt, $sformatf("%0d", $urandom_range(9))};
        end
        1: begin
          txt = "0";
          repeat (ndig) txt = {txt, $sformatf("%0d", $urandom_range(7))};
        end
        default: begin
          if ($urandom_range(1)) txt = "0x";
          else txt = "0X";
          repeat (ndig) begin
            k = $urandom_range(21);
            txt = {txt, hex_set.substr(k, k)};
          end
        end
      endcase
    end
    for (int i = 0; i < txt.len(); i++) begin
      ch = txt[i];
      if (base_sel == 2 && i > 1 && ch >= "a" && ch <= "f" && $urandom_range(1))
        ch = ch - 8'h20;
      lit_chars.push_back(ch);
    end
    lit_chars.push_back($urandom_range(1) ? ChNul : char_t'($urandom_range(255)));
    lit_len = lit_chars.size();
    repeat ($urandom_range(2)) lit_chars.push_back(char_t'($urandom_range(255)));
  endtask

  task automatic run_random(input int src_pct, input int snk_pct);
    int sent;
    src_idle = src_pct;
    snk_idle = snk_pct;
    sent     = 0;
    while (sent < PhaseItems) begin
      build_string();
      foreach (lit_chars[i]) send_item(lit_chars[i], (i == 0), 1'b0, '0);
      sent += lit_len;
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.char_code     = '0;
    in_ch.string_start  = 1'b0;
    out_ch.ready        = 1'b0;
    row_typed           = 1'b0;
    row_want            = '0;
    pred_phase          = ScanLead;
    pred_acc            = '0;
    pred_neg            = 1'b0;
    errors              = 0;
    cycles              = 0;
    items_sent          = 0;
    values_checked      = 0;
    src_idle            = 37;
    snk_idle            = 78;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i])
      send_item(directed[i].ch, directed[i].start, directed[i].typed, directed[i].want);

    run_random(37, 78);
    wait_for_results();
    run_random(78, 37);
    wait_for_results();
    run_random(0, 0);

    in_ch.valid <= 1'b0;
    snk_idle    = 0;
    @(negedge clk_i);
    while (expected_values.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("tb: %0d characters sent, %0d values checked", items_sent, values_checked);
    $display("tb: blanks, signs, all three bases, wraparound, noise and idle patterns covered");
    if (errors == 0 && expected_values.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/ilp_pkg.sv
rtl/ilp_if.sv
rtl/integer_literal_parser_unit.sv
tb/tb.sv
